### sv/sitins_pkg.sv
// Shared types and constants for the sorted extent table insert unit.
// No dependencies; imported by sorted_interval_table_insert_unit.
package sitins_pkg;

    localparam int LBA_W      = 64;
    localparam int RIDX_W     = 7;
    localparam int POS_W      = 7;
    localparam int CNT_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int MODE_W     = 1;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 144;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED   = 3'd0,
        ST_ZERO_START = 3'd1,
        ST_OVL_PREV   = 3'd2,
        ST_OVL_NEXT   = 3'd3,
        ST_FULL       = 3'd4,
        ST_READ       = 3'd5
    } t_status;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 1'b0,
        MODE_READ   = 1'b1
    } t_mode;

    typedef struct packed {
        logic [LBA_W-1:0] last_lba;
        logic [LBA_W-1:0] first_lba;
    } t_entry;

endpackage

### sv/sorted_interval_table_insert_unit.sv
// Sorted extent table with overlap-checked insert and indexed read.
// Depends on sitins_pkg (status codes, entry type, port widths).
//
// Usage: requests enter on the s_axis channel, one result per request leaves
// on the m_axis channel. s_axis_tuser selects insert or read; s_axis_tdata
// carries the first and last block address and the read index. The result
// carries the status in m_axis_tuser and position, entry count and the entry
// read in m_axis_tdata.
// Extents live in one single-port-read memory, sorted by first address.
// An insert binary-searches the table (one memory read per cycle), then
// moves the entries from the sorted position upward one place at one entry
// per cycle, writes the new extent and registers the result. A rejected
// insert ends when the search does, and a zero start skips the search; a
// read reads its entry and then registers the result. One request is
// worked on at a time; s_axis_tready is high only when the unit is free.
// The result sits in an output register, so the next request is taken
// while the receiver stalls; a further result waits until that register
// drains. Reset empties the table (count to zero) at once; the memory
// contents need no clearing.
module sorted_interval_table_insert_unit #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [63:0] first_lba, [127:64] last_lba, [134:128] read_index, [135] zero
    input  logic [sitins_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] mode
    input  logic [sitins_pkg::MODE_W-1:0]    s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [6:0] position, [14:7] entry_count, [78:15] read_first,
    // [142:79] read_last, [143] zero
    output logic [sitins_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [2:0] status
    output logic [sitins_pkg::STATUS_W-1:0]  m_axis_tuser
);
    import sitins_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (CW > RIDX_W) ? CW : RIDX_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_PLACE  = 6'b001000,
        S_READ   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_entry mem [TABLE_DEPTH];

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_lo, n_lo;
    logic [CW-1:0]      r_hi, n_hi;
    logic [AW-1:0]      r_mid, n_mid;
    logic [AW-1:0]      r_j, n_j;
    logic [LBA_W-1:0]   r_first, n_first;
    logic [LBA_W-1:0]   r_last, n_last;
    logic [LBA_W-1:0]   r_prev_end, n_prev_end;
    logic [LBA_W-1:0]   r_next_start, n_next_start;
    logic               r_hit, n_hit;
    t_status            r_status, n_status;
    logic [IW-1:0]      r_pos, n_pos;
    logic [LBA_W-1:0]   r_rfirst, n_rfirst;
    logic [LBA_W-1:0]   r_rlast, n_rlast;
    t_entry             r_rd_data;
    logic               r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]  r_out_user, n_out_user;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;

    logic               in_acc;
    logic               out_load;
    logic [LBA_W-1:0]   in_first;
    logic [LBA_W-1:0]   in_last;
    logic [RIDX_W-1:0]  in_ridx;
    t_mode              in_mode;

    logic               go_left;
    logic [CW-1:0]      sl_lo, sl_hi;
    logic [CW:0]        sl_sum;
    logic               ovl_prev, ovl_next, tbl_full;

    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    t_entry             wr_data;

    assign in_first = s_axis_tdata[LBA_W-1:0];
    assign in_last  = s_axis_tdata[2*LBA_W-1:LBA_W];
    assign in_ridx  = s_axis_tdata[2*LBA_W+RIDX_W-1:2*LBA_W];
    assign in_mode  = t_mode'(s_axis_tuser);

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // binary search step on the entry at r_mid
    assign go_left  = r_first < r_rd_data.first_lba;
    assign sl_lo    = go_left ? r_lo : CW'(r_mid) + CW'(1);
    assign sl_hi    = go_left ? CW'(r_mid) : r_hi;
    assign sl_sum   = (CW+1)'(sl_lo) + (CW+1)'(sl_hi);

    assign ovl_prev = (r_lo != '0) && (r_first <= r_prev_end);
    assign ovl_next = (r_lo != r_count) && (r_last >= r_next_start);
    assign tbl_full = (r_count == CW'(TABLE_DEPTH));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_j          = r_j;
        n_first      = r_first;
        n_last       = r_last;
        n_prev_end   = r_prev_end;
        n_next_start = r_next_start;
        n_hit        = r_hit;
        n_status     = r_status;
        n_pos        = r_pos;
        n_rfirst     = r_rfirst;
        n_rlast      = r_rlast;
        rd_addr      = r_mid;
        wr_en        = 1'b0;
        wr_addr      = r_j;
        wr_data      = r_rd_data;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_first  = in_first;
                    n_last   = in_last;
                    n_rfirst = '0;
                    n_rlast  = '0;
                    if (in_mode == MODE_READ) begin
                        n_status = ST_READ;
                        n_pos    = IW'(in_ridx);
                        n_hit    = IW'(in_ridx) < IW'(r_count);
                        rd_addr  = AW'(in_ridx);
                        n_state  = S_READ;
                    end else if (in_first == '0) begin
                        n_status = ST_ZERO_START;
                        n_pos    = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_lo    = '0;
                        n_hi    = r_count;
                        n_mid   = AW'(r_count >> 1);
                        rd_addr = AW'(r_count >> 1);
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (r_lo != r_hi) begin
                    if (go_left) begin
                        n_next_start = r_rd_data.first_lba;
                    end else begin
                        n_prev_end = r_rd_data.last_lba;
                    end
                    n_lo    = sl_lo;
                    n_hi    = sl_hi;
                    n_mid   = sl_sum[AW:1];
                    rd_addr = sl_sum[AW:1];
                end else begin
                    n_pos = IW'(r_lo);
                    if (ovl_prev) begin
                        n_status = ST_OVL_PREV;
                        n_state  = S_DONE;
                    end else if (ovl_next) begin
                        n_status = ST_OVL_NEXT;
                        n_state  = S_DONE;
                    end else if (tbl_full) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else if (r_lo == r_count) begin
                        n_state = S_PLACE;
                    end else begin
                        n_j     = AW'(r_count - CW'(1));
                        rd_addr = AW'(r_count - CW'(1));
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                // entry r_j moves up one place; read of r_j-1 overlaps
                wr_en   = 1'b1;
                wr_addr = r_j + AW'(1);
                wr_data = r_rd_data;
                if (r_j == AW'(r_lo)) begin
                    n_state = S_PLACE;
                end else begin
                    n_j     = r_j - AW'(1);
                    rd_addr = r_j - AW'(1);
                end
            end
            S_PLACE: begin
                wr_en             = 1'b1;
                wr_addr           = AW'(r_lo);
                wr_data.first_lba = r_first;
                wr_data.last_lba  = r_last;
                n_count           = r_count + CW'(1);
                n_status          = ST_INSERTED;
                n_state           = S_DONE;
            end
            S_READ: begin
                if (r_hit) begin
                    n_rfirst = r_rd_data.first_lba;
                    n_rlast  = r_rd_data.last_lba;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = (r_out_valid && !m_axis_tready) || out_load;
        n_out_user  = r_out_user;
        n_out_data  = r_out_data;
        if (out_load) begin
            n_out_user = r_status;
            n_out_data = {1'b0, r_rlast, r_rfirst, CNT_W'(r_count), POS_W'(r_pos)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_j          <= n_j;
        r_first      <= n_first;
        r_last       <= n_last;
        r_prev_end   <= n_prev_end;
        r_next_start <= n_next_start;
        r_hit        <= n_hit;
        r_status     <= n_status;
        r_pos        <= n_pos;
        r_rfirst     <= n_rfirst;
        r_rlast      <= n_rlast;
        r_out_user   <= n_out_user;
        r_out_data   <= n_out_data;
    end

    // extent memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> (r_count == $past(r_count) + CW'(1)))
        else $error("entry count changed by other than one");

    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> ((r_lo <= r_hi) && (r_hi <= r_count)))
        else $error("search window out of range");

    a_write_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((CW'(wr_addr) <= r_count) && !tbl_full))
        else $error("table write beyond stored entries");

    a_insert_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_READ))
            |-> (m_axis_tdata[M_TDATA_W-1:POS_W+CNT_W] == '0))
        else $error("insert result carries entry data");

endmodule
